[hw/rtl/charged_isolation_sum_with_timing_assert.svh]
// Assertion macros for the isolation sum RTL.
// Needs nothing else; included by the modules that carry checks.
`ifndef CHARGED_ISOLATION_SUM_WITH_TIMING_ASSERT_SVH
`define CHARGED_ISOLATION_SUM_WITH_TIMING_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define CISUM_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cisum check failed");

// Next-cycle implication, disabled during reset
`define CISUM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cisum check failed");

`endif

[hw/rtl/cisum_pkg.sv]
// Shared types and constants for the charged isolation sum block.
// No dependencies; every other RTL file but the assertion macro header uses it.
`default_nettype none

package cisum_pkg;

    // Field widths
    localparam int ETA_W   = 12;
    localparam int PHI_W   = 11;
    localparam int Z_W     = 10;
    localparam int T_W     = 12;
    localparam int PT_W    = 16;
    localparam int KIND_W  = 3;
    localparam int IDX_W   = 8;
    localparam int SUM_W   = 24;
    localparam int DETA_W  = ETA_W + 1;
    localparam int DPHI_W  = PHI_W;
    localparam int DR2_W   = 25;

    // Configuration registers
    localparam int CONE_W     = 22;
    localparam int ZWIN_W     = 10;
    localparam int TWIN_W     = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 22;

    localparam logic [CFG_IDX_W-1:0] CFG_CONE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZWIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TWIN = 2'd2;

    localparam logic [CONE_W-1:0] CONE_RESET = 22'd2116;
    localparam logic [ZWIN_W-1:0] ZWIN_RESET = 10'd20;
    localparam logic [TWIN_W-1:0] TWIN_RESET = 12'd10;

    // Default list length
    localparam int MAX_CANDIDATES_DEF = 256;

    // Phi wraps at 1440 angle units
    localparam int PHI_PERIOD = 1440;
    localparam int PHI_HALF   = 720;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // Command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_CAND = 1'b1;

    // Charged particle kinds
    localparam logic [KIND_W-1:0] KIND_CHARGED_HADRON = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ELECTRON       = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MUON           = 3'd4;

    // One request on the input channel
    typedef struct packed {
        logic                     command;
        logic signed [ETA_W-1:0]  eta;
        logic signed [PHI_W-1:0]  phi;
        logic signed [Z_W-1:0]    z_poca;
        logic signed [T_W-1:0]    time_req;
        logic [PT_W-1:0]          pt;
        logic [KIND_W-1:0]        particle_kind;
        logic                     has_track;
        logic [IDX_W-1:0]         self_index;
        logic                     last;
    } t_item;

    // Control that travels down the pipeline with each request
    typedef struct packed {
        logic valid;
        logic is_load;
        logic last;
        logic hit;
        logic time_ok;
    } t_ctl;

endpackage

`default_nettype wire

[hw/rtl/cisum_ifs.sv]
// Valid/ready channel interfaces: candidate input, sum output, config writes.
// Depends on cisum_pkg for field widths.
`default_nettype none

interface cisum_in_if;
    logic                               valid;
    logic                               ready;
    logic                               command;
    logic signed [cisum_pkg::ETA_W-1:0] eta;
    logic signed [cisum_pkg::PHI_W-1:0] phi;
    logic signed [cisum_pkg::Z_W-1:0]   z_poca;
    logic signed [cisum_pkg::T_W-1:0]   time_req;
    logic [cisum_pkg::PT_W-1:0]         pt;
    logic [cisum_pkg::KIND_W-1:0]       particle_kind;
    logic                               has_track;
    logic [cisum_pkg::IDX_W-1:0]        self_index;
    logic                               last;

    modport source (
        output valid, command, eta, phi, z_poca, time_req, pt, particle_kind,
               has_track, self_index, last,
        input  ready
    );
    modport sink (
        input  valid, command, eta, phi, z_poca, time_req, pt, particle_kind,
               has_track, self_index, last,
        output ready
    );
endinterface

interface cisum_out_if;
    logic                         valid;
    logic                         ready;
    logic [cisum_pkg::SUM_W-1:0]  charged_iso_sum;
    logic [cisum_pkg::SUM_W-1:0]  timed_iso_sum;

    modport source (output valid, charged_iso_sum, timed_iso_sum, input ready);
    modport sink   (input valid, charged_iso_sum, timed_iso_sum, output ready);
endinterface

interface cisum_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [cisum_pkg::CFG_IDX_W-1:0]   index;
    logic [cisum_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hw/rtl/cisum_front.sv]
// Input register, reference object, candidate counter and the cheap cuts.
// Depends on cisum_pkg.
`default_nettype none

module cisum_front #(
    parameter int MAX_CANDIDATES = cisum_pkg::MAX_CANDIDATES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_accept,
    input  cisum_pkg::t_item                     i_item,
    input  logic [cisum_pkg::ZWIN_W-1:0]         i_zwin,
    input  logic [cisum_pkg::TWIN_W-1:0]         i_twin,
    output cisum_pkg::t_ctl                      o_ctl,
    output logic signed [cisum_pkg::DETA_W-1:0]  o_deta,
    output logic signed [cisum_pkg::DPHI_W-1:0]  o_dphi,
    output logic [cisum_pkg::PT_W-1:0]           o_pt
);
    import cisum_pkg::*;

    localparam int CNT_W = $clog2(MAX_CANDIDATES + 1);
    localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CANDIDATES);
    localparam logic signed [PHI_W:0] PHI_HALF_S   = (PHI_W+1)'(PHI_HALF);
    localparam logic signed [PHI_W:0] PHI_PERIOD_S = (PHI_W+1)'(PHI_PERIOD);

    // Input stage
    logic  r_s1_valid;
    t_item r_s1;

    // Reference object and list position
    logic signed [ETA_W-1:0] r_ref_eta;
    logic signed [PHI_W-1:0] r_ref_phi;
    logic signed [Z_W-1:0]   r_ref_z;
    logic signed [T_W-1:0]   r_ref_time;
    logic                    r_ref_trk;
    logic [IDX_W-1:0]        r_ref_idx;
    logic [CNT_W-1:0]        r_cnt;

    // Stage two
    t_ctl                     r_ctl;
    logic signed [DETA_W-1:0] r_deta;
    logic signed [DPHI_W-1:0] r_dphi;
    logic [PT_W-1:0]          r_pt;

    logic signed [DETA_W-1:0] deta;
    logic signed [PHI_W:0]    dphi_raw;
    logic signed [PHI_W:0]    dphi_wrap;
    logic signed [Z_W:0]      dz;
    logic [Z_W:0]             abs_dz;
    logic signed [T_W:0]      dt;
    logic [T_W:0]             abs_dt;
    logic                     is_cand;
    logic                     counted;
    logic                     charged;
    logic                     self_hit;
    logic                     dz_ok;
    logic                     dt_ok;
    t_ctl                     n_ctl;

    // Latch an accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_accept) begin
            r_s1 <= i_item;
        end
    end

    // Differences against the reference, with phi wrapped into one period
    always_comb begin
        deta      = DETA_W'(r_s1.eta) - DETA_W'(r_ref_eta);
        dphi_raw  = (PHI_W+1)'(r_s1.phi) - (PHI_W+1)'(r_ref_phi);
        if (dphi_raw >= PHI_HALF_S) begin
            dphi_wrap = dphi_raw - PHI_PERIOD_S;
        end else if (dphi_raw < -PHI_HALF_S) begin
            dphi_wrap = dphi_raw + PHI_PERIOD_S;
        end else begin
            dphi_wrap = dphi_raw;
        end
        dz     = (Z_W+1)'(r_s1.z_poca) - (Z_W+1)'(r_ref_z);
        abs_dz = dz[Z_W] ? (Z_W+1)'(-dz) : (Z_W+1)'(dz);
        dt     = (T_W+1)'(r_s1.time_req) - (T_W+1)'(r_ref_time);
        abs_dt = dt[T_W] ? (T_W+1)'(-dt) : (T_W+1)'(dt);
        dz_ok  = abs_dz < {1'b0, i_zwin};
        dt_ok  = abs_dt < {1'b0, i_twin};
    end

    // Candidate selection
    always_comb begin
        is_cand  = (r_s1.command == CMD_CAND);
        counted  = is_cand && (r_cnt < CNT_MAX);
        charged  = (r_s1.particle_kind == KIND_CHARGED_HADRON) ||
                   (r_s1.particle_kind == KIND_ELECTRON) ||
                   (r_s1.particle_kind == KIND_MUON);
        self_hit = (CMP_W'(r_cnt) == CMP_W'(r_ref_idx));

        n_ctl.valid   = r_s1_valid;
        n_ctl.is_load = !is_cand;
        n_ctl.last    = r_s1.last;
        n_ctl.hit     = counted && !self_hit && charged && r_ref_trk &&
                        r_s1.has_track && dz_ok;
        n_ctl.time_ok = dt_ok;
    end

    // Update reference and counter as a request leaves the input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_eta  <= '0;
            r_ref_phi  <= '0;
            r_ref_z    <= '0;
            r_ref_time <= '0;
            r_ref_trk  <= 1'b0;
            r_ref_idx  <= '0;
            r_cnt      <= '0;
        end else if (i_en && r_s1_valid) begin
            if (!is_cand) begin
                r_ref_eta  <= r_s1.eta;
                r_ref_phi  <= r_s1.phi;
                r_ref_z    <= r_s1.z_poca;
                r_ref_time <= r_s1.time_req;
                r_ref_trk  <= r_s1.has_track;
                r_ref_idx  <= r_s1.self_index;
                r_cnt      <= '0;
            end else if (r_s1.last) begin
                r_cnt <= '0;
            end else if (counted) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    // Stage two register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_deta <= deta;
            r_dphi <= DPHI_W'(dphi_wrap);
            r_pt   <= r_s1.pt;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_deta = r_deta;
    assign o_dphi = r_dphi;
    assign o_pt   = r_pt;

endmodule

`default_nettype wire

[hw/rtl/cisum_cone.sv]
// Cone test: square the angle differences, then add and compare to the radius.
// Depends on cisum_pkg.
`default_nettype none

module cisum_cone (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  cisum_pkg::t_ctl                      i_ctl,
    input  logic signed [cisum_pkg::DETA_W-1:0]  i_deta,
    input  logic signed [cisum_pkg::DPHI_W-1:0]  i_dphi,
    input  logic [cisum_pkg::PT_W-1:0]           i_pt,
    input  logic [cisum_pkg::CONE_W-1:0]         i_cone,
    output cisum_pkg::t_ctl                      o_ctl,
    output logic [cisum_pkg::PT_W-1:0]           o_pt
);
    import cisum_pkg::*;

    localparam int SQE_W = 2 * DETA_W;
    localparam int SQP_W = 2 * DPHI_W;

    logic signed [SQE_W-1:0] sq_eta;
    logic signed [SQP_W-1:0] sq_phi;

    // Square stage
    t_ctl             r_sq_ctl;
    logic [DR2_W-2:0] r_sq_eta;
    logic [DR2_W-2:0] r_sq_phi;
    logic [PT_W-1:0]  r_sq_pt;

    // Compare stage
    logic [DR2_W-1:0] dr2;
    logic             in_cone;
    t_ctl             n_ctl;
    t_ctl             r_ctl;
    logic [PT_W-1:0]  r_pt;

    // Both squares are non-negative and below 2^24
    assign sq_eta = i_deta * i_deta;
    assign sq_phi = i_dphi * i_dphi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_ctl <= '0;
        end else if (i_en) begin
            r_sq_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq_eta <= sq_eta[DR2_W-2:0];
            r_sq_phi <= {{(DR2_W-1-SQP_W){1'b0}}, sq_phi};
            r_sq_pt  <= i_pt;
        end
    end

    // Add and compare against the squared radius
    always_comb begin
        dr2     = {1'b0, r_sq_eta} + {1'b0, r_sq_phi};
        in_cone = dr2 < DR2_W'(i_cone);
        n_ctl     = r_sq_ctl;
        n_ctl.hit = r_sq_ctl.hit && in_cone;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pt <= r_sq_pt;
        end
    end

    assign o_ctl = r_ctl;
    assign o_pt  = r_pt;

endmodule

`default_nettype wire

[hw/rtl/cisum_accum.sv]
// Saturating sum accumulators, result register and pipeline advance.
// Depends on cisum_pkg and the assertion macro header.
`default_nettype none

`include "charged_isolation_sum_with_timing_assert.svh"

module cisum_accum (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cisum_pkg::t_ctl               i_ctl,
    input  logic [cisum_pkg::PT_W-1:0]    i_pt,
    input  logic                          i_out_ready,
    output logic                          o_en,
    output logic                          o_out_valid,
    output logic [cisum_pkg::SUM_W-1:0]   o_sum,
    output logic [cisum_pkg::SUM_W-1:0]   o_timed
);
    import cisum_pkg::*;

    logic [SUM_W-1:0] r_sum;
    logic [SUM_W-1:0] r_timed;
    logic [SUM_W-1:0] n_sum;
    logic [SUM_W-1:0] n_timed;
    logic             r_out_valid;
    logic [SUM_W-1:0] r_out_sum;
    logic [SUM_W-1:0] r_out_timed;

    logic [SUM_W:0]   sum_add;
    logic [SUM_W:0]   timed_add;
    logic [SUM_W-1:0] sum_sat;
    logic [SUM_W-1:0] timed_sat;
    logic             emit;

    // Stall only when a result is due and the result register is still full
    assign emit = i_ctl.valid && i_ctl.last;
    assign o_en = !(emit && r_out_valid && !i_out_ready);

    // Saturating adds and next sums
    always_comb begin
        sum_add   = {1'b0, r_sum} + (SUM_W+1)'(i_pt);
        timed_add = {1'b0, r_timed} + (SUM_W+1)'(i_pt);
        sum_sat   = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
        timed_sat = timed_add[SUM_W] ? SUM_MAX : timed_add[SUM_W-1:0];

        if (i_ctl.is_load) begin
            n_sum   = '0;
            n_timed = '0;
        end else begin
            n_sum   = i_ctl.hit ? sum_sat : r_sum;
            n_timed = (i_ctl.hit && i_ctl.time_ok) ? timed_sat : r_timed;
        end
    end

    // Accumulate; clear after the list ends
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_timed <= '0;
        end else if (o_en && i_ctl.valid) begin
            if (i_ctl.last) begin
                r_sum   <= '0;
                r_timed <= '0;
            end else begin
                r_sum   <= n_sum;
                r_timed <= n_timed;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_en && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en && emit) begin
            r_out_sum   <= n_sum;
            r_out_timed <= n_timed;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_sum       = r_out_sum;
    assign o_timed     = r_out_timed;

    // The timed sum is a subset of the charged sum
    `CISUM_ASSERT(a_acc_order, i_clk, i_rst_n, 1'b1, r_timed <= r_sum)
    `CISUM_ASSERT(a_out_order, i_clk, i_rst_n, r_out_valid, r_out_timed <= r_out_sum)
    // A load or the end of a list leaves both sums empty
    `CISUM_ASSERT_NEXT(a_clear, i_clk, i_rst_n,
        o_en && i_ctl.valid && (i_ctl.last || i_ctl.is_load),
        r_sum == '0 && r_timed == '0)

endmodule

`default_nettype wire

[hw/rtl/charged_isolation_sum_with_timing.sv]
// Top level of the charged isolation sum with timing cut.
// Depends on cisum_pkg, cisum_ifs, cisum_front, cisum_cone and cisum_accum.
`default_nettype none

// Takes one request per clock while the pipeline is not paused. A load
// request sets the reference object and starts a new list; candidate
// requests are summed into a charged isolation sum and a timed sum, and the
// request marked last returns both sums. A request passes the input
// register, the difference stage, the square stage and the cone compare
// stage on its way into the accumulator and result register. The pipeline
// pauses only while a result is due and the previous one still waits in the
// result register; requests that give no result keep flowing meanwhile.
// Configuration writes are taken every cycle and should be made while no
// list is in flight.
module charged_isolation_sum_with_timing #(
    parameter int MAX_CANDIDATES = cisum_pkg::MAX_CANDIDATES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cisum_cfg_if.sink    i_cfg,
    cisum_in_if.sink     i_in,
    cisum_out_if.source  o_res
);
    import cisum_pkg::*;

    logic [CONE_W-1:0] r_cone;
    logic [ZWIN_W-1:0] r_zwin;
    logic [TWIN_W-1:0] r_twin;

    logic en;
    t_item item;

    t_ctl                     s2_ctl;
    logic signed [DETA_W-1:0] s2_deta;
    logic signed [DPHI_W-1:0] s2_dphi;
    logic [PT_W-1:0]          s2_pt;
    t_ctl                     s4_ctl;
    logic [PT_W-1:0]          s4_pt;

    // Configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cone <= CONE_RESET;
            r_zwin <= ZWIN_RESET;
            r_twin <= TWIN_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_CONE: r_cone <= i_cfg.data[CONE_W-1:0];
                CFG_ZWIN: r_zwin <= i_cfg.data[ZWIN_W-1:0];
                CFG_TWIN: r_twin <= i_cfg.data[TWIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Gather the request fields
    always_comb begin
        item.command       = i_in.command;
        item.eta           = i_in.eta;
        item.phi           = i_in.phi;
        item.z_poca        = i_in.z_poca;
        item.time_req      = i_in.time_req;
        item.pt            = i_in.pt;
        item.particle_kind = i_in.particle_kind;
        item.has_track     = i_in.has_track;
        item.self_index    = i_in.self_index;
        item.last          = i_in.last;
    end

    assign i_in.ready = en;

    cisum_front #(
        .MAX_CANDIDATES (MAX_CANDIDATES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_accept (i_in.valid),
        .i_item   (item),
        .i_zwin   (r_zwin),
        .i_twin   (r_twin),
        .o_ctl    (s2_ctl),
        .o_deta   (s2_deta),
        .o_dphi   (s2_dphi),
        .o_pt     (s2_pt)
    );

    cisum_cone u_cone (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (s2_ctl),
        .i_deta  (s2_deta),
        .i_dphi  (s2_dphi),
        .i_pt    (s2_pt),
        .i_cone  (r_cone),
        .o_ctl   (s4_ctl),
        .o_pt    (s4_pt)
    );

    cisum_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (s4_ctl),
        .i_pt        (s4_pt),
        .i_out_ready (o_res.ready),
        .o_en        (en),
        .o_out_valid (o_res.valid),
        .o_sum       (o_res.charged_iso_sum),
        .o_timed     (o_res.timed_iso_sum)
    );

endmodule

`default_nettype wire

[verif/charged_isolation_sum_with_timing_test.sv]
// Self-checking testbench for charged_isolation_sum_with_timing: directed table, random lists.
// Depends on cisum_pkg, cisum_ifs and the RTL under hw/rtl; predicts the sums in-line.
`timescale 1ns / 100ps

module charged_isolation_sum_with_timing_test;
    import cisum_pkg::*;

    localparam int LIST_CAP     = MAX_CANDIDATES_DEF;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DIR_ROWS     = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam logic [KIND_W-1:0] KIND_NEUTRAL_HADRON = 3'd2;
    localparam logic [KIND_W-1:0] KIND_PHOTON         = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SPARE_5        = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_6        = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_7        = 3'd7;

    typedef struct packed {
        logic [SUM_W-1:0] charged;
        logic [SUM_W-1:0] timed;
    } t_sums;

    typedef struct {
        t_item it;
        bit    typed;
        t_sums want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cisum_cfg_if cfg_ch ();
    cisum_in_if  in_ch ();
    cisum_out_if res_ch ();

    charged_isolation_sum_with_timing #(
        .MAX_CANDIDATES(LIST_CAP)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_ch),
        .i_in   (in_ch),
        .o_res  (res_ch)
    );

    always #5 i_clk = ~i_clk;

    // Predicted block state: windows, reference object, list progress
    logic [CONE_W-1:0]       cone_r2;
    logic [ZWIN_W-1:0]       z_win;
    logic [TWIN_W-1:0]       t_win;
    logic signed [ETA_W-1:0] anchor_eta;
    logic signed [PHI_W-1:0] anchor_phi;
    logic signed [Z_W-1:0]   anchor_z;
    logic signed [T_W-1:0]   anchor_t;
    logic                    anchor_trk;
    logic [IDX_W-1:0]        anchor_slot;
    int                      cand_pos;
    logic [SUM_W-1:0]        charged_acc;
    logic [SUM_W-1:0]        timed_acc;

    t_sums expected_sums[$];
    t_row  stim_rows[$];
    int    mismatches = 0;
    int    cycle_count = 0;
    bit    hold_request = 1'b0;

    // Directed requests at reset windows (cone 2116, dz 20, dt 10).
    // Columns: cmd, eta, phi, z, t, pt, kind, trk, self, last, typed, charged, timed
    int dir_tbl [0:DIR_ROWS-1][0:12] = '{
        // candidate before any load: reset reference has no track
        '{CMD_CAND,     0,     0,    0,     0,   100, KIND_CHARGED_HADRON, 1,   0, 1, 1, 0, 0},
        // load marked last returns zeros
        '{CMD_LOAD,     0,     0,    0,     0,     0, KIND_CHARGED_HADRON, 1,   1, 1, 1, 0, 0},
        '{CMD_CAND,     0,     0,    0,     0,    10, KIND_CHARGED_HADRON, 1,   0, 0, 0, 0, 0},
        // own position, skipped
        '{CMD_CAND,     0,     0,    0,     0,  1000, KIND_CHARGED_HADRON, 1,   0, 0, 0, 0, 0},
        '{CMD_CAND,     0,     0,    0,     9,    20, KIND_ELECTRON,       1,   0, 0, 0, 0, 0},
        '{CMD_CAND,     0,     0,    0,   -10,    40, KIND_MUON,           1,   0, 0, 0, 0, 0},
        // neutral and unused kinds are counted but never summed
        '{CMD_CAND,     0,     0,    0,     0,   500, KIND_NEUTRAL_HADRON, 1,   0, 0, 0, 0, 0},
        '{CMD_CAND,     0,     0,    0,     0,   500, KIND_PHOTON,         1,   0, 0, 0, 0, 0},
        '{CMD_CAND,     0,     0,    0,     0,   500, KIND_SPARE_5,        1,   0, 0, 0, 0, 0},
        '{CMD_CAND,     0,     0,    0,     0,   500, KIND_SPARE_6,        1,   0, 0, 0, 0, 0},
        '{CMD_CAND,     0,     0,    0,     0,   500, KIND_SPARE_7,        1,   0, 0, 0, 0, 0},
        '{CMD_CAND,     0,     0,    0,     0,   500, KIND_CHARGED_HADRON, 0,   0, 0, 0, 0, 0},
        '{CMD_CAND,     0,     0,   20,     0,   500, KIND_CHARGED_HADRON, 1,   0, 0, 0, 0, 0},
        '{CMD_CAND,     0,     0,  -19,     0,    80, KIND_CHARGED_HADRON, 1, 255, 0, 0, 0, 0},
        // cone edge: 46^2 is not below 2116, 45^2 + 9^2 is
        '{CMD_CAND,    46,     0,    0,     0,   500, KIND_CHARGED_HADRON, 1,   0, 0, 0, 0, 0},
        '{CMD_CAND,    45,     9,    0,     0,     1, KIND_MUON,           1,   0, 1, 0, 0, 0},
        // extreme reference, then phi wrap across the seam
        '{CMD_LOAD,  2047,   719,  511,  2047, 65535, KIND_SPARE_7,        1, 255, 0, 0, 0, 0},
        '{CMD_CAND,  2047,  -720,  511,  2047, 65535, KIND_CHARGED_HADRON, 1,   0, 0, 0, 0, 0},
        '{CMD_CAND,  2047,  1023,  511,  2047,     7, KIND_CHARGED_HADRON, 1,   0, 0, 0, 0, 0},
        '{CMD_CAND,  2047,   700,  492,  2038,     9, KIND_ELECTRON,       1,   0, 0, 0, 0, 0},
        '{CMD_CAND, -2048, -1024, -512, -2048, 65535, KIND_MUON,           1,   0, 1, 0, 0, 0},
        '{CMD_LOAD, -2048, -1024, -512, -2048,     0, KIND_CHARGED_HADRON, 0,   0, 0, 0, 0, 0},
        '{CMD_CAND, -2048, -1024, -512, -2048, 65535, KIND_CHARGED_HADRON, 1,   0, 0, 0, 0, 0},
        // load mid-list restarts and, marked last, returns zeros
        '{CMD_LOAD,     0,     0,    0,     0,     0, KIND_CHARGED_HADRON, 1,   0, 1, 1, 0, 0}
    };

    function automatic void reset_prediction();
        cone_r2     = CONE_RESET;
        z_win       = ZWIN_RESET;
        t_win       = TWIN_RESET;
        anchor_eta  = '0;
        anchor_phi  = '0;
        anchor_z    = '0;
        anchor_t    = '0;
        anchor_trk  = 1'b0;
        anchor_slot = '0;
        cand_pos    = 0;
        charged_acc = '0;
        timed_acc   = '0;
    endfunction

    // Advance the predicted state by one request; return 1 when it yields sums
    function automatic bit isolation_step(input t_item req, output t_sums sums);
        int deta;
        int dphi;
        int dz;
        int dt;
        int dr2;
        int slot;
        int nsum;
        bit charged;
        sums = '0;
        if (req.command == CMD_LOAD) begin
            anchor_eta  = req.eta;
            anchor_phi  = req.phi;
            anchor_z    = req.z_poca;
            anchor_t    = req.time_req;
            anchor_trk  = req.has_track;
            anchor_slot = req.self_index;
            cand_pos    = 0;
            charged_acc = '0;
            timed_acc   = '0;
            return req.last;
        end
        if (cand_pos < LIST_CAP) begin
            slot = cand_pos;
            cand_pos++;
            charged = (req.particle_kind == KIND_CHARGED_HADRON) ||
                      (req.particle_kind == KIND_ELECTRON) ||
                      (req.particle_kind == KIND_MUON);
            if (slot != anchor_slot && charged) begin
                deta = req.eta - anchor_eta;
                dphi = (req.phi - anchor_phi) % PHI_PERIOD;
                if (dphi < 0) dphi += PHI_PERIOD;
                if (dphi >= PHI_HALF) dphi -= PHI_PERIOD;
                dz = req.z_poca - anchor_z;
                if (dz < 0) dz = -dz;
                dt = req.time_req - anchor_t;
                if (dt < 0) dt = -dt;
                dr2 = deta * deta + dphi * dphi;
                if (dr2 < int'(cone_r2) && anchor_trk && req.has_track &&
                        dz < int'(z_win)) begin
                    nsum = int'(charged_acc) + int'(req.pt);
                    charged_acc = (nsum > int'(SUM_MAX)) ? SUM_MAX : nsum[SUM_W-1:0];
                    if (dt < int'(t_win)) begin
                        nsum = int'(timed_acc) + int'(req.pt);
                        timed_acc = (nsum > int'(SUM_MAX)) ? SUM_MAX : nsum[SUM_W-1:0];
                    end
                end
            end
        end
        if (req.last) begin
            sums.charged = charged_acc;
            sums.timed   = timed_acc;
            cand_pos     = 0;
            charged_acc  = '0;
            timed_acc    = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic int near(input int centre, input int spread);
        int off;
        off = $urandom_range(0, 2 * spread);
        return centre + off - spread;
    endfunction

    function automatic t_item any_item();
        t_item it;
        it.command       = 1'($urandom);
        it.eta           = ETA_W'($urandom);
        it.phi           = PHI_W'($urandom);
        it.z_poca        = Z_W'($urandom);
        it.time_req      = T_W'($urandom);
        it.pt            = PT_W'($urandom);
        it.particle_kind = KIND_W'($urandom);
        it.has_track     = 1'($urandom);
        it.self_index    = IDX_W'($urandom);
        it.last          = ($urandom_range(0, 4) == 0);
        return it;
    endfunction

    task automatic drive_request(input t_item it);
        in_ch.command       <= it.command;
        in_ch.eta           <= it.eta;
        in_ch.phi           <= it.phi;
        in_ch.z_poca        <= it.z_poca;
        in_ch.time_req      <= it.time_req;
        in_ch.pt            <= it.pt;
        in_ch.particle_kind <= it.particle_kind;
        in_ch.has_track     <= it.has_track;
        in_ch.self_index    <= it.self_index;
        in_ch.last          <= it.last;
    endtask

    // Write the three windows back to back, optionally poking the unused index
    task automatic program_windows(input logic [CFG_DATA_W-1:0] cone,
                                   input logic [CFG_DATA_W-1:0] zw,
                                   input logic [CFG_DATA_W-1:0] tw,
                                   input bit poke_spare);
        logic [CFG_IDX_W-1:0]  idx_q[$];
        logic [CFG_DATA_W-1:0] val_q[$];
        int k;
        idx_q = '{CFG_CONE, CFG_ZWIN, CFG_TWIN};
        val_q = '{cone, zw, tw};
        if (poke_spare) begin
            idx_q.insert(idx_q.size(), CFG_SPARE);
            val_q.insert(val_q.size(), CFG_DATA_W'($urandom));
        end
        for (k = 0; k < idx_q.size(); k++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx_q[k];
            cfg_ch.data  <= val_q[k];
            @(posedge i_clk);
            while (!cfg_ch.ready) @(posedge i_clk);
            case (idx_q[k])
                CFG_CONE: cone_r2 = val_q[k][CONE_W-1:0];
                CFG_ZWIN: z_win   = val_q[k][ZWIN_W-1:0];
                CFG_TWIN: t_win   = val_q[k][TWIN_W-1:0];
                default: ;
            endcase
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // Random lists: mostly a load plus candidates near it, some noise
    task automatic plan_lists(input int item_goal, input int len_max);
        int made;
        int len;
        int choice;
        int k;
        int sz;
        int st;
        int g_eta;
        int g_phi;
        int g_z;
        int g_t;
        t_row row;
        made  = 0;
        g_eta = 0;
        g_phi = 0;
        g_z   = 0;
        g_t   = 0;
        sz = int'(z_win) + 3;
        if (sz > 600) sz = 600;
        st = int'(t_win) + 3;
        if (st > 2100) st = 2100;
        row.typed = 1'b0;
        row.want  = '0;
        while (made < item_goal) begin
            len    = $urandom_range(1, len_max);
            choice = $urandom_range(0, 99);
            if (choice < 12) begin
                repeat ($urandom_range(1, 5)) begin
                    row.it = any_item();
                    stim_rows.insert(stim_rows.size(), row);
                    made++;
                end
                continue;
            end
            // below 20 the list reuses the held reference
            if (choice >= 20) begin
                row.it = any_item();
                row.it.command   = CMD_LOAD;
                row.it.has_track = ($urandom_range(0, 9) != 0);
                row.it.last      = (choice < 25);
                if ($urandom_range(0, 3) != 0)
                    row.it.self_index = IDX_W'($urandom_range(0, len - 1));
                g_eta = row.it.eta;
                g_phi = row.it.phi;
                g_z   = row.it.z_poca;
                g_t   = row.it.time_req;
                stim_rows.insert(stim_rows.size(), row);
                made++;
            end
            for (k = 0; k < len; k++) begin
                row.it = any_item();
                if ($urandom_range(0, 6) != 0) begin
                    row.it.eta       = ETA_W'(near(g_eta, 60));
                    row.it.phi       = PHI_W'(near(g_phi, 60));
                    row.it.z_poca    = Z_W'(near(g_z, sz));
                    row.it.time_req  = T_W'(near(g_t, st));
                    row.it.has_track = ($urandom_range(0, 9) != 0);
                    if ($urandom_range(0, 9) < 7) begin
                        case ($urandom_range(0, 2))
                            0: row.it.particle_kind = KIND_CHARGED_HADRON;
                            1: row.it.particle_kind = KIND_ELECTRON;
                            default: row.it.particle_kind = KIND_MUON;
                        endcase
                    end
                    if ($urandom_range(0, 9) == 0) row.it.pt = '1;
                end
                row.it.command = CMD_CAND;
                row.it.last    = (k == len - 1);
                stim_rows.insert(stim_rows.size(), row);
                made++;
            end
        end
    endtask

    // One list longer than the cap, full pt, own position at the last counted slot
    task automatic plan_long_list();
        t_row row;
        int k;
        row.typed = 1'b0;
        row.want  = '0;
        row.it    = '0;
        row.it.command    = CMD_LOAD;
        row.it.eta        = ETA_W'(100);
        row.it.phi        = PHI_W'(-700);
        row.it.has_track  = 1'b1;
        row.it.self_index = IDX_W'(LIST_CAP - 1);
        stim_rows.insert(stim_rows.size(), row);
        for (k = 0; k < LIST_CAP + 44; k++) begin
            row.it = any_item();
            row.it.command       = CMD_CAND;
            row.it.eta           = ETA_W'(near(100, 40));
            row.it.phi           = PHI_W'(near(-700, 40));
            row.it.z_poca        = Z_W'(near(0, 100));
            row.it.particle_kind = KIND_CHARGED_HADRON;
            row.it.has_track     = 1'b1;
            row.it.pt            = '1;
            row.it.last          = (k == LIST_CAP + 43);
            stim_rows.insert(stim_rows.size(), row);
        end
    endtask

    // Offer the planned requests in bursts with gaps; predict on each accept
    task automatic send_rows();
        int pos;
        int burst;
        int gap;
        t_sums got;
        pos   = 0;
        burst = $urandom_range(1, 24);
        gap   = 0;
        while (pos < stim_rows.size()) begin
            if (gap > 0) begin
                gap--;
                @(posedge i_clk);
            end else begin
                drive_request(stim_rows[pos].it);
                in_ch.valid <= 1'b1;
                @(posedge i_clk);
                while (!in_ch.ready) @(posedge i_clk);
                if (isolation_step(stim_rows[pos].it, got))
                    expected_sums.insert(expected_sums.size(),
                                         stim_rows[pos].typed ? stim_rows[pos].want : got);
                pos++;
                burst--;
                if (burst == 0) begin
                    burst = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24);
                    gap   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
                    if (gap > 0 && pos < stim_rows.size()) in_ch.valid <= 1'b0;
                end
            end
        end
        in_ch.valid <= 1'b0;
        stim_rows.delete();
    endtask

    // Wait out pending sums, then let requests without a result drain
    task automatic settle();
        while (expected_sums.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic flag_mismatch(input string what, input int unsigned want_v,
                                 input int unsigned got_v);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at cycle %0d: %s expected %0d got %0d",
                     cycle_count, what, want_v, got_v);
    endtask

    // Pace the result side: rotating stall patterns, plus one long hold on request
    initial begin : result_pacing
        int hold_count;
        int mode_left;
        logic [15:0] stall_pat;
        hold_count = 0;
        mode_left  = 0;
        stall_pat  = '1;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_count   = HOLD_CYCLES;
            end
            if (hold_count > 0) begin
                hold_count--;
                res_ch.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode_left = $urandom_range(32, 256);
                    case ($urandom_range(0, 3))
                        0: stall_pat = '1;
                        1: stall_pat = 16'($urandom) | 16'h0001;
                        2: stall_pat = 16'($urandom & $urandom) | 16'h0001;
                        default: stall_pat = 16'h00FF;
                    endcase
                end
                mode_left--;
                res_ch.ready <= stall_pat[0];
                stall_pat = {stall_pat[0], stall_pat[15:1]};
            end
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        t_sums want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_sums.size() == 0) begin
                flag_mismatch("unexpected result, charged sum", 0, res_ch.charged_iso_sum);
            end else begin
                want = expected_sums.pop_front();
                if (want.charged !== res_ch.charged_iso_sum)
                    flag_mismatch("charged_iso_sum", want.charged, res_ch.charged_iso_sum);
                if (want.timed !== res_ch.timed_iso_sum)
                    flag_mismatch("timed_iso_sum", want.timed, res_ch.timed_iso_sum);
            end
        end
    end

    // Drop the run if it runs past the cycle limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("charged_isolation_sum_with_timing_test: done, errors");
            $finish;
        end
    end

    initial begin : run
        int r;
        t_row row;
        i_rst_n      <= 1'b0;
        in_ch.valid  <= 1'b0;
        drive_request('0);
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= CFG_CONE;
        cfg_ch.data  <= '0;
        reset_prediction();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table at reset windows
        for (r = 0; r < DIR_ROWS; r++) begin
            row.it.command       = 1'(dir_tbl[r][0]);
            row.it.eta           = ETA_W'(dir_tbl[r][1]);
            row.it.phi           = PHI_W'(dir_tbl[r][2]);
            row.it.z_poca        = Z_W'(dir_tbl[r][3]);
            row.it.time_req      = T_W'(dir_tbl[r][4]);
            row.it.pt            = PT_W'(dir_tbl[r][5]);
            row.it.particle_kind = KIND_W'(dir_tbl[r][6]);
            row.it.has_track     = 1'(dir_tbl[r][7]);
            row.it.self_index    = IDX_W'(dir_tbl[r][8]);
            row.it.last          = 1'(dir_tbl[r][9]);
            row.typed            = 1'(dir_tbl[r][10]);
            row.want.charged     = SUM_W'(dir_tbl[r][11]);
            row.want.timed       = SUM_W'(dir_tbl[r][12]);
            stim_rows.insert(stim_rows.size(), row);
        end
        send_rows();
        settle();

        // Widest windows, with the over-long full-pt list
        program_windows('1, 22'd1023, 22'd4095, 1'b0);
        plan_lists(300, 24);
        plan_long_list();
        send_rows();
        settle();

        // Zero windows: nothing passes
        program_windows('0, '0, '0, 1'b0);
        plan_lists(120, 12);
        send_rows();
        settle();

        // Short lists behind a long result hold-off
        program_windows(22'd3000, 22'd30, 22'd25, 1'b0);
        plan_lists(400, 3);
        hold_request = 1'b1;
        send_rows();
        settle();

        // Random windows, random upper data bits on the narrow registers
        repeat (4) begin
            program_windows(22'($urandom_range(100, 40000)),
                            {12'($urandom), 10'($urandom_range(1, 80))},
                            {10'($urandom), 12'($urandom_range(1, 150))},
                            1'b1);
            plan_lists(130, 40);
            send_rows();
            settle();
        end

        if (mismatches == 0 && expected_sums.size() == 0)
            $display("charged_isolation_sum_with_timing_test: done, clean");
        else
            $display("charged_isolation_sum_with_timing_test: done, errors");
        $finish;
    end

endmodule
